// ===== design/wafr_pkg.sv =====
// Shared types and constants of the word array fragment framer.
package wafr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HDR_W   = 24;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned FRAG_W  = 10;
  localparam int unsigned FNUM_W  = 6;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SLOT_W  = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MAX_FRAGMENT_BYTES = 2'd0;
  localparam logic [IDX_W-1:0] REG_BYTE_ORDER         = 2'd1;
  localparam logic [IDX_W-1:0] REG_ARRAY_ID           = 2'd2;
  localparam logic [IDX_W-1:0] REG_WORDS_IN_ARRAY     = 2'd3;

  // Byte slots of one item in the output stream.
  localparam logic [SLOT_W-1:0] SLOT_HDR_HI   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_HDR_MID  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_HDR_LO   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_DATA_0   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_DATA_1   = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_DATA_2   = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_DATA_3   = 3'd6;

  typedef struct packed {
    logic [11:0] max_fragment_bytes;
    logic        byte_order;
    logic [5:0]  array_id;
    logic [14:0] words_in_array;
  } cfg_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              has_hdr;
    logic [HDR_W-1:0]  hdr;
    logic              eof;
    logic              eoa;
    logic              ovf;
    logic              byte_order;
  } cmd_t;

endpackage

// ===== design/wafr_if.sv =====
// Channel interfaces: input words and output bytes.
interface wafr_word_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface wafr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       end_of_fragment;
  logic       end_of_array;
  logic       fragment_overflow;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_header, output end_of_fragment,
                  output end_of_array, output fragment_overflow, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input is_header, input end_of_fragment,
                input end_of_array, input fragment_overflow, input last_of_run,
                output ready);
endinterface

// ===== design/word_array_fragment_framer.sv =====
// Top level of the word array fragment framer.
// Takes the 32-bit words of an array and emits a byte stream cut into fragments of
// max_fragment_bytes/4 words (at least one). Each fragment opens with a 3-byte header,
// sent high byte first: array id [23:18], fragment number low bits [17:13], word count
// [12:3], a zero encrypted bit, the byte order bit and a last-fragment bit. Each word then
// follows as four bytes, big-endian when byte_order is 0 and little-endian when it is 1.
// After the array's final word the counters return to their start values, so the next
// word opens a new array. A fragment numbered above 31 carries fragment_overflow on all
// its bytes and sends only the low five bits of its number.
// Each word goes out as four bytes, or seven when it opens a fragment, through the
// byte-wide output serializer. The front end classifies a word in the cycle it is taken
// and parks it in a two-entry queue, so input is accepted while the serializer still
// drains earlier words and a stalled output does not stop the front until the queue fills.
// Write configuration only while the block is idle; words_in_array is sampled when an
// array starts and max_fragment_bytes when a fragment starts.
module word_array_fragment_framer
  import wafr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  wafr_word_if.sink         word_in,
  wafr_byte_if.source       byte_out
);

  cfg_t cfg;
  logic q_in_valid;
  logic q_in_ready;
  cmd_t q_in_data;
  logic q_out_valid;
  logic q_out_ready;
  cmd_t q_out_data;

  // Configuration registers; writes must land only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_fragment_bytes <= 12'd4;
      cfg.byte_order         <= 1'b0;
      cfg.array_id           <= 6'd0;
      cfg.words_in_array     <= 15'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_FRAGMENT_BYTES: cfg.max_fragment_bytes <= cfg_data[11:0];
        REG_BYTE_ORDER:         cfg.byte_order         <= cfg_data[0];
        REG_ARRAY_ID:           cfg.array_id           <= cfg_data[5:0];
        REG_WORDS_IN_ARRAY:     cfg.words_in_array     <= cfg_data[14:0];
        default:                cfg <= cfg;
      endcase
    end
  end

  // Classify each word: array and fragment bookkeeping, header build.
  wafr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .word_in (word_in),
    .cfg     (cfg),
    .q_valid (q_in_valid),
    .q_ready (q_in_ready),
    .q_data  (q_in_data)
  );

  // Hold classified words until the serializer takes them.
  wafr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_data   (q_in_data),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  // Serialize header and data bytes into the registered output.
  wafr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_out_valid),
    .q_ready  (q_out_ready),
    .q_data   (q_out_data),
    .byte_out (byte_out)
  );

endmodule

// ===== design/wafr_front.sv =====
// Front end: accept words, track array and fragment counts, build headers.
module wafr_front
  import wafr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  wafr_word_if.sink    word_in,
  input  cfg_t         cfg,
  output logic         q_valid,
  input  logic         q_ready,
  output cmd_t         q_data
);

  logic [CNT_W-1:0]  words_left_in_array;
  logic [FRAG_W-1:0] words_left_in_fragment;
  logic [FNUM_W-1:0] fragment_number;

  logic              array_start;
  logic [CNT_W-1:0]  wla_eff;
  logic [FRAG_W-1:0] wlf_eff;
  logic [FNUM_W-1:0] fn_eff;
  logic [FRAG_W-1:0] per;
  logic              frag_start;
  logic              last_frag;
  logic [FRAG_W-1:0] count;
  logic [FRAG_W-1:0] wlf_new;
  logic [CNT_W-1:0]  wla_new;
  logic              eof;
  logic              eoa;
  logic              accept;

  assign accept = word_in.valid && q_ready;
  assign word_in.ready = q_ready;
  assign q_valid = word_in.valid;

  always_comb begin
    array_start = (words_left_in_array == '0);
    if (array_start) begin
      wla_eff = (cfg.words_in_array == '0) ? CNT_W'(1) : cfg.words_in_array;
      wlf_eff = '0;
      fn_eff  = '0;
    end else begin
      wla_eff = words_left_in_array;
      wlf_eff = words_left_in_fragment;
      fn_eff  = fragment_number;
    end
    per        = (cfg.max_fragment_bytes[11:2] == '0) ? FRAG_W'(1)
                                                      : cfg.max_fragment_bytes[11:2];
    frag_start = (wlf_eff == '0);
    last_frag  = (wla_eff <= CNT_W'(per));
    count      = last_frag ? wla_eff[FRAG_W-1:0] : per;
    wlf_new    = (frag_start ? count : wlf_eff) - FRAG_W'(1);
    wla_new    = wla_eff - CNT_W'(1);
    eof        = (wlf_new == '0);
    eoa        = (wla_new == '0);

    q_data.word       = word_in.data_word;
    q_data.has_hdr    = frag_start;
    q_data.hdr        = {cfg.array_id, fn_eff[4:0], count, 1'b0, cfg.byte_order, last_frag};
    q_data.eof        = eof;
    q_data.eoa        = eoa;
    q_data.ovf        = fn_eff[5];
    q_data.byte_order = cfg.byte_order;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left_in_array    <= '0;
      words_left_in_fragment <= '0;
      fragment_number        <= '0;
    end else if (accept) begin
      words_left_in_array <= wla_new;
      if (eoa) begin
        words_left_in_fragment <= '0;
        fragment_number        <= '0;
      end else begin
        words_left_in_fragment <= wlf_new;
        if (eof) begin
          // Advance the count; bit 5 goes sticky once the low bits wrap.
          fragment_number <= {fn_eff[5] | (&fn_eff[4:0]), fn_eff[4:0] + 5'd1};
        end else begin
          fragment_number <= fn_eff;
        end
      end
    end
  end

endmodule

// ===== design/wafr_queue.sv =====
// Two-entry queue between front and back.
module wafr_queue
  import wafr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/wafr_back.sv =====
// Back end: serialize each item into header and data bytes.
module wafr_back
  import wafr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  output logic         q_ready,
  input  cmd_t         q_data,
  wafr_byte_if.source  byte_out
);

  cmd_t              cmd;
  logic              active;
  logic [SLOT_W-1:0] slot;
  logic              out_valid;
  logic              can_emit;
  logic              final_byte;
  logic [BYTE_W-1:0] sel_byte;
  logic [1:0]        lane;

  assign can_emit   = !out_valid || byte_out.ready;
  assign final_byte = (slot == SLOT_DATA_3);
  assign q_ready    = can_emit && (!active || final_byte);
  assign byte_out.valid = out_valid;

  always_comb begin
    // Lane starts at the most significant byte for big-endian and steps down.
    lane = cmd.byte_order ? 2'(slot - SLOT_DATA_0) : 2'(SLOT_DATA_3 - slot);
    unique case (slot)
      SLOT_HDR_HI:  sel_byte = cmd.hdr[23:16];
      SLOT_HDR_MID: sel_byte = cmd.hdr[15:8];
      SLOT_HDR_LO:  sel_byte = cmd.hdr[7:0];
      default:      sel_byte = cmd.word[lane*BYTE_W +: BYTE_W];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid <= active;
      end
      // Load the next item when idle or as the final byte of the current one goes out.
      if (q_valid && q_ready) begin
        active <= 1'b1;
        cmd    <= q_data;
        slot   <= q_data.has_hdr ? SLOT_HDR_HI : SLOT_DATA_0;
      end else if (can_emit && active) begin
        if (final_byte) begin
          active <= 1'b0;
        end else begin
          slot <= slot + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && active) begin
      byte_out.out_byte          <= sel_byte;
      byte_out.is_header         <= (slot < SLOT_DATA_0);
      byte_out.end_of_fragment   <= cmd.eof && final_byte;
      byte_out.end_of_array      <= cmd.eoa && final_byte;
      byte_out.fragment_overflow <= cmd.ovf;
      byte_out.last_of_run       <= final_byte;
    end
  end

endmodule
